/* hw/rtl/keyed_score_table_mean_median_assert.svh */
// assertion macros for the keyed score table
`ifndef KEYED_SCORE_TABLE_MEAN_MEDIAN_ASSERT_SVH
`define KEYED_SCORE_TABLE_MEAN_MEDIAN_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is high
`define KSTMM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, also during reset
`define KSTMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KSTMM_ASSERT(lbl, clk, rst, prop, msg)
`define KSTMM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/kstmm_pkg.sv */
`default_nettype none
package kstmm_pkg;
   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int KEY_W   = 32;
   localparam int SCORE_W = 16;
   localparam int ENTRY_W = 1 + KEY_W + SCORE_W;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   // input commands
   localparam logic CMD_SET    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // table walk kinds
   localparam logic [1:0] PK_SCAN  = 2'd0;
   localparam logic [1:0] PK_RADIX = 2'd1;
   localparam logic [1:0] PK_FINAL = 2'd2;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       pass_begin;
      logic [1:0] pass_kind;
      logic       update;
      logic       div_begin;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic pass_done;
      logic div_done;
      logic bit_last;
      logic empty;
   } ctl_stat_type;
endpackage
`default_nettype wire

/* hw/rtl/kstmm_ram.sv */
`default_nettype none
module kstmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

/* hw/rtl/kstmm_datapath.sv */
`default_nettype none
module kstmm_datapath #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire kstmm_pkg::ctl_cmd_type     cmd,
   output kstmm_pkg::ctl_stat_type         stat,
   input  wire logic                       req_cmd,
   input  wire logic [31:0]                req_entry_key,
   input  wire logic [15:0]                req_score_value,
   output logic      [1:0]                 rsp_status,
   output logic      [6:0]                 rsp_entry_count,
   output logic      [23:0]                rsp_mean_q8,
   output logic      [15:0]                rsp_median_value
);
   import kstmm_pkg::*;
   `include "keyed_score_table_mean_median_assert.svh"

   localparam int IW  = $clog2(TABLE_ENTRIES);
   localparam int CW  = $clog2(TABLE_ENTRIES + 1);
   localparam int SW  = SCORE_W + CW;
   localparam int DW  = SW + 8;
   localparam int DVW = $clog2(DW);

   // table walk control
   logic [IW-1:0] wk_ff, wk_in, pidx_ff;
   logic act_ff, act_in, pend_ff, plast_ff;
   logic [1:0] pk_ff;
   // ram port
   logic we;
   logic [IW-1:0] wa;
   logic [ENTRY_W-1:0] wd, rd;
   // latched beat
   logic op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [SCORE_W-1:0] scr_ff;
   // scan results
   logic hit_ff, fre_ff;
   logic [IW-1:0] hidx_ff, fidx_ff;
   logic [SCORE_W-1:0] hsc_ff;
   // table totals
   logic [CW-1:0] cnt_ff;
   logic [SW-1:0] sum_ff;
   logic [1:0] stat_ff;
   // divider
   logic dv_act_ff;
   logic [DVW-1:0] dv_ff;
   logic [DW-1:0] dd_ff, q_ff;
   logic [CW-1:0] rem_ff;
   logic [CW:0] trial;
   logic tge;
   // median select
   logic [CW-1:0] kr_ff, k0_ff, acc_ff, acc_in, cle_ff, cle_in;
   logic [SCORE_W-1:0] pre_ff, pre_in, mg_ff, mg_in, hm, v2;
   logic [3:0] bt_ff;
   logic [SCORE_W-1:0] med_ff;
   logic two;
   logic rv;
   logic [KEY_W-1:0] rk;
   logic [SCORE_W-1:0] rs;
   logic [63:0] cnt64, q64;

   assign rv = rd[ENTRY_W-1];
   assign rk = rd[ENTRY_W-2:SCORE_W];
   assign rs = rd[SCORE_W-1:0];

   kstmm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(wk_ff), .rd_data(rd)
   );

   // walk counter, also used by the clearing pass
   always_comb begin
      wk_in  = wk_ff;
      act_in = act_ff;
      if (cmd.pass_begin) begin
         wk_in  = '0;
         act_in = 1'b1;
      end else if (act_ff || cmd.clear) begin
         wk_in = wk_ff + 1'b1;
         if (wk_ff == IW'(TABLE_ENTRIES - 1)) begin
            wk_in  = '0;
            act_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wk_ff    <= '0;
         act_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         plast_ff <= 1'b0;
      end else begin
         wk_ff    <= wk_in;
         act_ff   <= act_in;
         pend_ff  <= act_ff;
         plast_ff <= act_ff && (wk_ff == IW'(TABLE_ENTRIES - 1));
      end
      pidx_ff <= wk_ff;
      if (cmd.pass_begin) begin
         pk_ff <= cmd.pass_kind;
      end
   end

   // ram write mux: clearing pass or table update
   always_comb begin
      we = 1'b0;
      wa = wk_ff;
      wd = '0;
      if (cmd.clear) begin
         we = 1'b1;
      end else if (cmd.update) begin
         if (hit_ff) begin
            we = 1'b1;
            wa = hidx_ff;
            wd = {op_ff == CMD_SET, key_ff, scr_ff};
         end else if (op_ff == CMD_SET && fre_ff) begin
            we = 1'b1;
            wa = fidx_ff;
            wd = {1'b1, key_ff, scr_ff};
         end
      end
   end

   // per-entry counts for the select passes
   assign hm = (16'hFFFF << bt_ff) << 1;
   always_comb begin
      acc_in = acc_ff;
      cle_in = cle_ff;
      mg_in  = mg_ff;
      if (pend_ff && rv) begin
         if (((rs ^ pre_ff) & hm) == '0 && !rs[bt_ff]) begin
            acc_in = acc_ff + 1'b1;
         end
         if (rs <= pre_ff) begin
            cle_in = cle_ff + 1'b1;
         end else if (rs < mg_ff) begin
            mg_in = rs;
         end
      end
   end

   always_comb begin
      pre_in = pre_ff;
      pre_in[bt_ff] = !(kr_ff < acc_in);
   end

   assign two = ({1'b0, cle_in} > ({1'b0, k0_ff} + 1'b1));
   assign v2  = two ? pre_ff : mg_in;

   // divider step
   assign trial = {rem_ff, dd_ff[DW-1]};
   assign tge   = trial >= {1'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         sum_ff    <= '0;
         dv_act_ff <= 1'b0;
      end else begin
         // latch request beat
         if (cmd.load) begin
            op_ff  <= req_cmd;
            key_ff <= req_entry_key;
            scr_ff <= req_score_value;
            hit_ff <= 1'b0;
            fre_ff <= 1'b0;
         end
         // key search and free slot search
         if (pend_ff && pk_ff == PK_SCAN) begin
            if (rv && !hit_ff && rk == key_ff) begin
               hit_ff  <= 1'b1;
               hidx_ff <= pidx_ff;
               hsc_ff  <= rs;
            end
            if (!rv && !fre_ff) begin
               fre_ff  <= 1'b1;
               fidx_ff <= pidx_ff;
            end
         end
         // table update and totals
         if (cmd.update) begin
            if (op_ff == CMD_SET) begin
               if (hit_ff) begin
                  stat_ff <= ST_OK;
                  sum_ff  <= sum_ff - SW'(hsc_ff) + SW'(scr_ff);
               end else if (fre_ff) begin
                  stat_ff <= ST_OK;
                  sum_ff  <= sum_ff + SW'(scr_ff);
                  cnt_ff  <= cnt_ff + 1'b1;
               end else begin
                  stat_ff <= ST_FULL;
               end
            end else begin
               if (hit_ff) begin
                  stat_ff <= ST_OK;
                  sum_ff  <= sum_ff - SW'(hsc_ff);
                  cnt_ff  <= cnt_ff - 1'b1;
               end else begin
                  stat_ff <= ST_ABSENT;
               end
            end
         end
         // mean: restoring divide of sum times 256 by count; also seeds the median select
         if (cmd.div_begin) begin
            dv_act_ff <= 1'b1;
            dv_ff     <= DVW'(DW - 1);
            dd_ff     <= {sum_ff, 8'd0};
            rem_ff    <= '0;
            q_ff      <= '0;
            kr_ff     <= (cnt_ff - 1'b1) >> 1;
            k0_ff     <= (cnt_ff - 1'b1) >> 1;
            pre_ff    <= '0;
            bt_ff     <= 4'd15;
         end else if (dv_act_ff) begin
            rem_ff <= tge ? CW'(trial - {1'b0, cnt_ff}) : trial[CW-1:0];
            q_ff   <= {q_ff[DW-2:0], tge};
            dd_ff  <= dd_ff << 1;
            dv_ff  <= dv_ff - 1'b1;
            if (dv_ff == '0) begin
               dv_act_ff <= 1'b0;
            end
         end
         // select pass accumulators
         if (cmd.pass_begin) begin
            acc_ff <= '0;
            cle_ff <= '0;
            mg_ff  <= '1;
         end else begin
            acc_ff <= acc_in;
            cle_ff <= cle_in;
            mg_ff  <= mg_in;
         end
         // one bit of the median per radix pass
         if (pend_ff && plast_ff && pk_ff == PK_RADIX) begin
            pre_ff <= pre_in;
            if (!(kr_ff < acc_in)) begin
               kr_ff <= kr_ff - acc_in;
            end
            bt_ff <= bt_ff - 1'b1;
         end
         // median from the final pass
         if (pend_ff && plast_ff && pk_ff == PK_FINAL) begin
            med_ff <= cnt_ff[0] ? pre_ff
                                : SCORE_W'(({1'b0, pre_ff} + {1'b0, v2}) >> 1);
         end
      end
   end

   // status toward the controller
   assign stat.clr_last  = wk_ff == IW'(TABLE_ENTRIES - 1);
   assign stat.pass_done = pend_ff && plast_ff;
   assign stat.div_done  = dv_act_ff && dv_ff == '0;
   assign stat.bit_last  = bt_ff == 4'd0;
   assign stat.empty     = cnt_ff == '0;

   // result fields
   assign cnt64 = 64'(cnt_ff);
   assign q64   = 64'(q_ff);
   assign rsp_status       = stat.empty ? ST_EMPTY : stat_ff;
   assign rsp_entry_count  = cnt64[6:0];
   assign rsp_mean_q8      = stat.empty ? 24'd0 : q64[23:0];
   assign rsp_median_value = stat.empty ? 16'd0 : med_ff;

   `KSTMM_ASSERT(a_cnt_range, clock, reset, cnt_ff <= CW'(TABLE_ENTRIES), "count above table size")
   `KSTMM_ASSERT(a_div_walk, clock, reset, !(dv_act_ff && act_ff), "divide overlaps table walk")
   `KSTMM_ASSERT(a_upd_quiet, clock, reset, cmd.update |-> !act_ff && !pend_ff, "update during walk")
endmodule
`default_nettype wire

/* hw/rtl/kstmm_ctrl.sv */
`default_nettype none
module kstmm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output logic                         rsp_valid,
   output kstmm_pkg::ctl_cmd_type       cmd,
   input  wire kstmm_pkg::ctl_stat_type stat
);
   import kstmm_pkg::*;
   `include "keyed_score_table_mean_median_assert.svh"

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_UPD   = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_RAD   = 4'd6;
   localparam logic [3:0] S_FIN   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0] state_ff, state_in;

   // sequencing of the phases of one beat
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load       = 1'b1;
               cmd.pass_begin = 1'b1;
               cmd.pass_kind  = PK_SCAN;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.pass_done) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (stat.empty) begin
               state_in = S_RESP;
            end else begin
               cmd.div_begin = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.pass_begin = 1'b1;
               cmd.pass_kind  = PK_RADIX;
               state_in       = S_RAD;
            end
         end
         S_RAD: begin
            if (stat.pass_done) begin
               cmd.pass_begin = 1'b1;
               if (stat.bit_last) begin
                  cmd.pass_kind = PK_FINAL;
                  state_in      = S_FIN;
               end else begin
                  cmd.pass_kind = PK_RADIX;
               end
            end
         end
         S_FIN: begin
            if (stat.pass_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   `KSTMM_ASSERT(a_one_strobe, clock, reset, rsp_valid |=> !rsp_valid, "result strobe twice")
   `KSTMM_ASSERT(a_take_busy, clock, reset, (start && !busy) |=> busy, "beat taken but not busy")
   `KSTMM_ASSERT(a_idle_quiet, clock, reset, !(state_ff == S_IDLE && stat.pass_done), "walk in idle")
endmodule
`default_nettype wire

/* hw/rtl/keyed_score_table_mean_median.sv */
// channel   ports                        handshake
// request   req_cmd/entry_key/score      start & !busy
// result    rsp_status/count/mean/median rsp_valid, one cycle
//
// a beat runs a key search walk, a divide of clog2(N+1) + 24 steps, sixteen
// counting walks for the median bits and one closing walk; each walk visits
// every table entry in turn, bound by the single read port of the table memory.
// a new beat is accepted only once the last one has given its result.
// a beat that leaves the table empty skips divide and median.
// after reset a clearing pass over all N entries holds busy high.
// a result is shown for one cycle and cannot be stalled by the receiver.
`default_nettype none
module keyed_score_table_mean_median #(
   parameter int TABLE_ENTRIES = kstmm_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_entry_key,
   input  wire logic [15:0] req_score_value,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_entry_count,
   output logic [23:0]      rsp_mean_q8,
   output logic [15:0]      rsp_median_value
);
   import kstmm_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // phase sequencer
   kstmm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .cmd(cmd), .stat(stat)
   );

   // table, totals, divider and median select
   kstmm_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_cmd(req_cmd), .req_entry_key(req_entry_key),
      .req_score_value(req_score_value),
      .rsp_status(rsp_status), .rsp_entry_count(rsp_entry_count),
      .rsp_mean_q8(rsp_mean_q8), .rsp_median_value(rsp_median_value)
   );
endmodule
`default_nettype wire

/* tb/keyed_score_table_mean_median_checker.sv */
`default_nettype none
module keyed_score_table_mean_median_checker #(
   parameter int TABLE_ENTRIES = kstmm_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_entry_key,
   input  wire logic [15:0] req_score_value,
   input  wire logic        rsp_valid,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [6:0]  rsp_entry_count,
   input  wire logic [23:0] rsp_mean_q8,
   input  wire logic [15:0] rsp_median_value,
   output int               fail_count,
   output int               pending_count
);
   import kstmm_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  entry_count;
      logic [23:0] mean_q8;
      logic [15:0] median_value;
   } table_summary_type;

   // shadow copy of the table
   logic [31:0]          shadow_keys   [TABLE_ENTRIES];
   logic [15:0]          shadow_scores [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] shadow_valid = '0;
   logic [31:0]          shadow_sum = '0;

   table_summary_type expected_summaries[$];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // apply one command beat to the shadow table and return its summary
   function automatic table_summary_type apply_command(input logic cmd, input logic [31:0] key,
                                                       input logic [15:0] score);
      table_summary_type res;
      int hit;
      int free_slot;
      int n;
      logic [15:0] sorted[$];
      hit = -1;
      free_slot = -1;
      res = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (shadow_valid[i]) begin
            if (hit < 0 && shadow_keys[i] == key) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      res.status = ST_OK;
      if (cmd == CMD_SET) begin
         if (hit >= 0) begin
            shadow_sum = shadow_sum - shadow_scores[hit] + score;
            shadow_scores[hit] = score;
         end else if (free_slot >= 0) begin
            shadow_keys[free_slot] = key;
            shadow_scores[free_slot] = score;
            shadow_valid[free_slot] = 1'b1;
            shadow_sum = shadow_sum + score;
         end else begin
            res.status = ST_FULL;
         end
      end else begin
         if (hit >= 0) begin
            shadow_sum = shadow_sum - shadow_scores[hit];
            shadow_valid[hit] = 1'b0;
         end else begin
            res.status = ST_ABSENT;
         end
      end
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (shadow_valid[i]) sorted = {sorted, shadow_scores[i]};
      sorted.sort();
      n = sorted.size();
      if (n == 0) begin
         res.status = ST_EMPTY;
      end else begin
         res.entry_count = n[6:0];
         res.mean_q8 = 24'(({32'd0, shadow_sum} << 8) / n);
         if (n % 2 == 0)
            res.median_value = 16'(({1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]}) / 2);
         else
            res.median_value = sorted[(n-1)/2];
      end
      return res;
   endfunction

   // predict on each accepted request, compare each result beat
   always @(posedge clock) begin
      table_summary_type want;
      if (!reset) begin
         if (start && !busy)
            expected_summaries = {expected_summaries,
                                  apply_command(req_cmd, req_entry_key, req_score_value)};
         if (rsp_valid) begin
            if (expected_summaries.size() == 0) begin
               report("result beat with none pending", 32'd1, 32'd0);
            end else begin
               want = expected_summaries.pop_front();
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_entry_count !== want.entry_count)
                  report("entry_count", 32'(rsp_entry_count), 32'(want.entry_count));
               if (rsp_mean_q8 !== want.mean_q8)
                  report("mean_q8", 32'(rsp_mean_q8), 32'(want.mean_q8));
               if (rsp_median_value !== want.median_value)
                  report("median_value", 32'(rsp_median_value), 32'(want.median_value));
            end
         end
         pending_count = expected_summaries.size();
      end
   end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
   import kstmm_pkg::*;

   localparam int CYCLE_LIMIT = 20_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = CMD_SET;
   logic [31:0] req_entry_key = '0;
   logic [15:0] req_score_value = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_entry_count;
   logic [23:0] rsp_mean_q8;
   logic [15:0] rsp_median_value;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;

   logic [31:0] key_pool[96];

   always #2 clock = ~clock;

   keyed_score_table_mean_median DUT (
      .clock, .reset, .start, .busy, .req_cmd, .req_entry_key, .req_score_value,
      .rsp_valid, .rsp_status, .rsp_entry_count, .rsp_mean_q8, .rsp_median_value
   );

   keyed_score_table_mean_median_checker score_checker (
      .clock, .reset, .start, .busy, .req_cmd, .req_entry_key, .req_score_value,
      .rsp_valid, .rsp_status, .rsp_entry_count, .rsp_mean_q8, .rsp_median_value,
      .fail_count, .pending_count
   );

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // idle gap: mostly short, a few long
   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(40, 400);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 4);
   endfunction

   // present one command beat and hold it until accepted
   task automatic send_command(input logic cmd, input logic [31:0] key, input logic [15:0] score);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_entry_key <= key;
      req_score_value <= score;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [15:0] pick_score();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int set_weight[7];
      logic [31:0] key;
      int drain;
      set_weight = '{95, 20, 95, 50, 97, 10, 70};
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, replace, absent, back to empty
      send_command(CMD_REMOVE, 32'd5, 16'hFFFF);
      send_command(CMD_SET, 32'h0000_0000, 16'h0000);
      send_command(CMD_SET, 32'hFFFF_FFFF, 16'hFFFF);
      send_command(CMD_SET, 32'h0000_0000, 16'h1234);
      send_command(CMD_SET, 32'hA5A5_A5A5, 16'h0007);
      send_command(CMD_SET, 32'h5A5A_5A5A, 16'hFFFF);
      send_command(CMD_REMOVE, 32'h0000_0077, 16'h0000);
      send_command(CMD_SET, 32'h5A5A_5A5A, 16'h0001);
      send_command(CMD_REMOVE, 32'h0000_0000, 16'h0000);
      send_command(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000);
      send_command(CMD_REMOVE, 32'hA5A5_A5A5, 16'h0000);
      send_command(CMD_REMOVE, 32'h5A5A_5A5A, 16'h0000);
      send_command(CMD_REMOVE, 32'h5A5A_5A5A, 16'h0000);

      // random phases swing the table between full and empty
      for (int phase = 0; phase < 7; phase++) begin
         for (int n = 0; n < 250; n++) begin
            if ($urandom_range(0, 3) == 0) key = $urandom;
            else key = key_pool[$urandom_range(0, 95)];
            send_command(($urandom_range(0, 99) < set_weight[phase]) ? CMD_SET : CMD_REMOVE,
                         key, pick_score());
         end
      end
      start <= 1'b0;

      // drain outstanding results, then idle before reporting
      while (pending_count != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
